@@ hdl/tsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared constants and types of the touch switch debounce / stuck detect unit.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int DEVICES             = 8;
  localparam int SWITCHES_PER_DEVICE = 16;

  localparam int DEV_W   = 3;
  localparam int PAT_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CHAT_W  = 16;
  localparam int STUCK_W = 20;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 1;

  // only DEV_W bits of index reach the state, so at most 2**DEV_W rows
  localparam int DEV_ROWS  = (DEVICES < (1 << DEV_W)) ? DEVICES : (1 << DEV_W);
  localparam int DEV_IDX_W = (DEV_ROWS > 1) ? $clog2(DEV_ROWS) : 1;

  localparam logic [CHAT_W-1:0]  CHATTER_RESET = CHAT_W'(20);
  localparam logic [STUCK_W-1:0] STUCK_RESET   = STUCK_W'(10 * 1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHATTER = 1'b0,
    REG_STUCK   = 1'b1
  } tsd_reg_e;

  typedef struct packed {
    logic [CHAT_W-1:0]  chatter_ms;
    logic [STUCK_W-1:0] stuck_ms;
  } tsd_cfg_t;

  typedef struct packed {
    logic on;
    logic err;
    logic any;
    logic time_we;
  } tsd_cell_t;

endpackage

@@ hdl/tsd_in_if.sv @@
// ----------------------------------------------------------------------------
// tsd_in_if
// Input item channel: device index, raw touch pattern, timestamp.
// ----------------------------------------------------------------------------
interface tsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tsd_pkg::DEV_W-1:0]   device_index;
  logic [tsd_pkg::PAT_W-1:0]   switch_pattern;
  logic [tsd_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, device_index, switch_pattern, time_ms, input ready);
  modport sink   (input valid, device_index, switch_pattern, time_ms, output ready);
  modport monitor (input valid, ready, device_index, switch_pattern, time_ms);
endinterface

@@ hdl/tsd_out_if.sv @@
// ----------------------------------------------------------------------------
// tsd_out_if
// Result item channel: any-on flag, on mask and error mask of one device.
// ----------------------------------------------------------------------------
interface tsd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       any_on;
  logic [tsd_pkg::PAT_W-1:0]  on_mask;
  logic [tsd_pkg::PAT_W-1:0]  error_mask;

  modport source (output valid, any_on, on_mask, error_mask, input ready);
  modport sink   (input valid, any_on, on_mask, error_mask, output ready);
  modport monitor (input valid, ready, any_on, on_mask, error_mask);
endinterface

@@ hdl/tsd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tsd_cfg_regs
// Chatter time and stuck limit registers with a plain write port.
// ----------------------------------------------------------------------------
module tsd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tsd_pkg::CFG_W-1:0]       cfg_data_i,
  output tsd_pkg::tsd_cfg_t               cfg_o
);

  tsd_pkg::tsd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tsd_pkg::tsd_reg_e'(cfg_idx_i))
        tsd_pkg::REG_CHATTER: cfg_d.chatter_ms = cfg_data_i[tsd_pkg::CHAT_W-1:0];
        tsd_pkg::REG_STUCK:   cfg_d.stuck_ms   = cfg_data_i[tsd_pkg::STUCK_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chatter_ms <= tsd_pkg::CHATTER_RESET;
      cfg_q.stuck_ms   <= tsd_pkg::STUCK_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/tsd_switch_cell.sv @@
// ----------------------------------------------------------------------------
// tsd_switch_cell
// Next-state logic of one switch: press, stuck detection, chatter-gated release.
// ----------------------------------------------------------------------------
module tsd_switch_cell (
  input  logic                           pressed_i,
  input  logic                           on_i,
  input  logic                           err_i,
  input  logic [tsd_pkg::TIME_W-1:0]     on_time_i,
  input  logic [tsd_pkg::TIME_W-1:0]     time_i,
  input  tsd_pkg::tsd_cfg_t              cfg_i,
  output tsd_pkg::tsd_cell_t             cell_o
);

  logic [tsd_pkg::TIME_W-1:0] dur;
  logic                       over_stuck;
  logic                       over_chatter;

  // a switch turning on now has zero duration, so only a held switch can stick
  assign dur          = time_i - on_time_i;
  assign over_stuck   = on_i && (dur > tsd_pkg::TIME_W'(cfg_i.stuck_ms));
  assign over_chatter = dur > tsd_pkg::TIME_W'(cfg_i.chatter_ms);

  always_comb begin
    cell_o.on      = on_i;
    cell_o.err     = err_i;
    cell_o.any     = 1'b0;
    cell_o.time_we = 1'b0;
    if (pressed_i) begin
      if (!err_i) begin
        cell_o.any     = 1'b1;
        cell_o.time_we = !on_i;
        if (over_stuck) begin
          cell_o.on  = 1'b0;
          cell_o.err = 1'b1;
        end else begin
          cell_o.on  = 1'b1;
        end
      end
    end else begin
      cell_o.err = 1'b0;
      if (on_i && over_chatter) begin
        cell_o.on = 1'b0;
      end
    end
  end

endmodule

@@ hdl/touch_switch_debounce_stuck_detect_unit.sv @@
// ----------------------------------------------------------------------------
// touch_switch_debounce_stuck_detect_unit
// Per-switch debouncer with stuck-press detection for several touch devices.
// ----------------------------------------------------------------------------
// One item is accepted per clock unless a stalled result holds the input. Its
// result loads into the result register after the input register. The item is
// captured in an input register, one device's flags and on-times are read,
// updated by sixteen switch cells and written back in the same cycle as the
// result register loads, so consecutive items for the same device see each
// other's updates. A stalled result holds both stages. On and error flags
// are cleared by reset; on-times are not and need no clearing.
module touch_switch_debounce_stuck_detect_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsd_pkg::CFG_W-1:0]      cfg_data_i,
  tsd_in_if.sink                         in_if,
  tsd_out_if.source                      out_if
);

  localparam int NSW = tsd_pkg::SWITCHES_PER_DEVICE;

  tsd_pkg::tsd_cfg_t cfg;

  tsd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic                         in_valid_q;
  logic [tsd_pkg::DEV_W-1:0]    dev_q;
  logic [tsd_pkg::PAT_W-1:0]    pat_q;
  logic [tsd_pkg::TIME_W-1:0]   time_q;

  logic                         out_valid_q;
  logic                         any_q;
  logic [tsd_pkg::PAT_W-1:0]    on_mask_q;
  logic [tsd_pkg::PAT_W-1:0]    err_mask_q;

  logic [NSW-1:0]               on_q  [tsd_pkg::DEV_ROWS];
  logic [NSW-1:0]               err_q [tsd_pkg::DEV_ROWS];
  logic [NSW-1:0][tsd_pkg::TIME_W-1:0] on_time_q [tsd_pkg::DEV_ROWS];

  logic                         advance;
  logic                         fire;
  logic                         dev_ok;
  logic                         upd;
  logic [tsd_pkg::DEV_IDX_W-1:0] row;
  logic [NSW-1:0]               on_row, err_row, on_d, err_d, any_v, we_v;
  tsd_pkg::tsd_cell_t           cell_res [NSW];

  assign advance     = !out_valid_q || out_if.ready;
  assign fire        = in_valid_q && advance;
  assign in_if.ready = !in_valid_q || advance;

  assign dev_ok = 32'(dev_q) < 32'(tsd_pkg::DEVICES);
  assign upd    = fire && dev_ok && (time_q != '0);
  assign row    = dev_q[tsd_pkg::DEV_IDX_W-1:0];

  assign on_row  = on_q[row];
  assign err_row = err_q[row];

  for (genvar j = 0; j < NSW; j++) begin : g_sw
    tsd_switch_cell u_cell (
      .pressed_i (pat_q[j]),
      .on_i      (on_row[j]),
      .err_i     (err_row[j]),
      .on_time_i (on_time_q[row][j]),
      .time_i    (time_q),
      .cfg_i     (cfg),
      .cell_o    (cell_res[j])
    );
    assign on_d[j]  = cell_res[j].on;
    assign err_d[j] = cell_res[j].err;
    assign any_v[j] = cell_res[j].any;
    assign we_v[j]  = cell_res[j].time_we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      dev_q  <= in_if.device_index;
      pat_q  <= in_if.switch_pattern;
      time_q <= in_if.time_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < tsd_pkg::DEV_ROWS; d++) begin
        on_q[d]  <= '0;
        err_q[d] <= '0;
      end
    end else if (upd) begin
      on_q[row]  <= on_d;
      err_q[row] <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NSW; j++) begin
      if (upd && we_v[j]) begin
        on_time_q[row][j] <= time_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (!dev_ok) begin
        any_q      <= 1'b0;
        on_mask_q  <= '0;
        err_mask_q <= '0;
      end else if (time_q == '0) begin
        any_q      <= 1'b0;
        on_mask_q  <= tsd_pkg::PAT_W'(on_row);
        err_mask_q <= tsd_pkg::PAT_W'(err_row);
      end else begin
        any_q      <= |any_v;
        on_mask_q  <= tsd_pkg::PAT_W'(on_d);
        err_mask_q <= tsd_pkg::PAT_W'(err_d);
      end
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.any_on     = any_q;
  assign out_if.on_mask    = on_mask_q;
  assign out_if.error_mask = err_mask_q;

endmodule

@@ hdl/tsd_checker.sv @@
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks of the debounce unit, bound to the top level.
// ----------------------------------------------------------------------------
module tsd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_any_on_i,
  input logic [tsd_pkg::PAT_W-1:0]  out_on_mask_i,
  input logic [tsd_pkg::PAT_W-1:0]  out_error_mask_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_any_on_i)
      && $stable(out_on_mask_i) && $stable(out_error_mask_i))
    else $error("result changed while stalled");

  // a switch in error is never reported on
  a_on_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_on_mask_i & out_error_mask_i) == '0)
    else $error("switch both on and in error");

  // a seen press leaves its switch on or in error
  a_any_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_any_on_i |-> (out_on_mask_i | out_error_mask_i) != '0)
    else $error("any_on without on or error flag");

  // an empty result stage never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind touch_switch_debounce_stuck_detect_unit tsd_checker u_tsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_any_on_i     (out_if.any_on),
  .out_on_mask_i    (out_if.on_mask),
  .out_error_mask_i (out_if.error_mask)
);

@@ sim/touch_switch_debounce_stuck_detect_unit_tb.sv @@
// ----------------------------------------------------------------------------
// touch_switch_debounce_stuck_detect_unit_tb
// Self-checking bench for the touch switch debounce / stuck detect unit.
// Scan items go in with random gaps and the results come out with random
// stalls. A per-switch model of the on, error and on-time state predicts
// every result, and the results are checked in order. The run starts with
// directed corner scans. It then plays random press/release sequences under
// several chatter and stuck-limit settings, and drains between settings.
// ----------------------------------------------------------------------------
module touch_switch_debounce_stuck_detect_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 4;

  typedef struct packed {
    logic [tsd_pkg::DEV_W-1:0]  dev;
    logic [tsd_pkg::PAT_W-1:0]  pattern;
    logic [tsd_pkg::TIME_W-1:0] time_ms;
  } scan_t;

  typedef struct packed {
    logic                      any_on;
    logic [tsd_pkg::PAT_W-1:0] on_mask;
    logic [tsd_pkg::PAT_W-1:0] err_mask;
  } flags_t;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic [tsd_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [tsd_pkg::CFG_W-1:0]     cfg_data_i = '0;

  tsd_in_if  scan_if ();
  tsd_out_if flags_if ();

  touch_switch_debounce_stuck_detect_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (scan_if),
    .out_if     (flags_if)
  );

  always #5ns clk_i = ~clk_i;

  wire scan_fire  = scan_if.valid && scan_if.ready;
  wire flags_fire = flags_if.valid && flags_if.ready;

  // model state
  logic [tsd_pkg::PAT_W-1:0]   on_q    [tsd_pkg::DEVICES];
  logic [tsd_pkg::PAT_W-1:0]   err_q   [tsd_pkg::DEVICES];
  logic [tsd_pkg::TIME_W-1:0]  since_q [tsd_pkg::DEVICES][tsd_pkg::SWITCHES_PER_DEVICE];
  logic [tsd_pkg::CHAT_W-1:0]  chatter_ms;
  logic [tsd_pkg::STUCK_W-1:0] stuck_ms;

  scan_t  pending_scans[$];
  flags_t expected_flags[$];
  flags_t want_flags;
  scan_t  next_scan;

  logic [tsd_pkg::TIME_W-1:0] dev_clock [tsd_pkg::DEVICES];
  logic [tsd_pkg::PAT_W-1:0]  dev_touch [tsd_pkg::DEVICES];

  logic scan_took = 1'b0;
  bit   scan_quiet = 1'b0;
  bit   flags_quiet = 1'b0;
  int   scan_gap = 0;
  int   flags_stall = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;

  function automatic flags_t apply_scan(input scan_t s);
    flags_t                     r;
    logic [tsd_pkg::TIME_W-1:0] held;
    r = '0;
    if (s.dev < tsd_pkg::DEVICES) begin
      if (s.time_ms != '0) begin
        for (int j = 0; j < tsd_pkg::SWITCHES_PER_DEVICE; j++) begin
          if (s.pattern[j]) begin
            if (!err_q[s.dev][j]) begin
              if (!on_q[s.dev][j]) begin
                on_q[s.dev][j]    = 1'b1;
                since_q[s.dev][j] = s.time_ms;
              end
              r.any_on = 1'b1;
              held = s.time_ms - since_q[s.dev][j];
              if (held > tsd_pkg::TIME_W'(stuck_ms)) begin
                on_q[s.dev][j]  = 1'b0;
                err_q[s.dev][j] = 1'b1;
              end
            end
          end else begin
            err_q[s.dev][j] = 1'b0;
            held = s.time_ms - since_q[s.dev][j];
            if (on_q[s.dev][j] && held > tsd_pkg::TIME_W'(chatter_ms)) begin
              on_q[s.dev][j] = 1'b0;
            end
          end
        end
      end
      r.on_mask  = on_q[s.dev];
      r.err_mask = err_q[s.dev];
    end
    return r;
  endfunction

  function automatic int pick_gap(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, longest);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_scan(input int dev, input int pattern,
                            input logic [tsd_pkg::TIME_W-1:0] t);
    scan_t s;
    s.dev     = tsd_pkg::DEV_W'(dev);
    s.pattern = tsd_pkg::PAT_W'(pattern);
    s.time_ms = t;
    pending_scans.push_back(s);
  endtask

  // press/release sequences per device with time moving forward by steps
  // scaled to the current chatter and stuck settings
  task automatic queue_random_scans(input int count, input int unsigned chat,
                                    input int unsigned stk);
    int                         d;
    int                         pick;
    logic [tsd_pkg::TIME_W-1:0] step;
    logic [tsd_pkg::TIME_W-1:0] t;
    for (int i = 0; i < tsd_pkg::DEVICES; i++) begin
      if ($urandom_range(0, 3) == 0) dev_clock[i] = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      else dev_clock[i] = $urandom;
      dev_touch[i] = '0;
    end
    d = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3) d = $urandom_range(0, tsd_pkg::DEVICES - 1);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        dev_touch[d][$urandom_range(0, tsd_pkg::PAT_W - 1)] ^= 1'b1;
      end else if (pick < 65) begin
        dev_touch[d][$urandom_range(0, tsd_pkg::PAT_W - 1)] ^= 1'b1;
        dev_touch[d][$urandom_range(0, tsd_pkg::PAT_W - 1)] ^= 1'b1;
      end else if (pick < 80) begin
        dev_touch[d] = dev_touch[d];
      end else if (pick < 88) begin
        dev_touch[d] = tsd_pkg::PAT_W'($urandom);
      end else if (pick < 94) begin
        dev_touch[d] = '0;
      end else begin
        dev_touch[d] = '1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) step = $urandom_range(0, chat + chat / 2 + 2);
      else if (pick < 62) step = chat + $urandom_range(0, 1);
      else if (pick < 77) step = $urandom_range(0, stk / 4 + 2);
      else if (pick < 92) step = stk + $urandom_range(0, 1);
      else step = $urandom;
      dev_clock[d] += step;
      t = ($urandom_range(0, 99) < 4) ? '0 : dev_clock[d];
      queue_scan(d, dev_touch[d], t);
    end
  endtask

  task automatic wait_drained();
    while (pending_scans.size() != 0 || scan_if.valid || expected_flags.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned chat, input int unsigned stk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tsd_pkg::REG_CHATTER;
    cfg_data_i <= tsd_pkg::CFG_W'(chat);
    @(negedge clk_i);
    cfg_idx_i  <= tsd_pkg::REG_STUCK;
    cfg_data_i <= tsd_pkg::CFG_W'(stk);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!scan_if.valid || scan_took) begin
        if (scan_gap > 0) begin
          scan_gap--;
          scan_if.valid <= 1'b0;
        end else if (pending_scans.size() > 0) begin
          next_scan = pending_scans.pop_front();
          scan_if.valid          <= 1'b1;
          scan_if.device_index   <= next_scan.dev;
          scan_if.switch_pattern <= next_scan.pattern;
          scan_if.time_ms        <= next_scan.time_ms;
          if ($urandom_range(0, 79) == 0) scan_quiet = !scan_quiet;
          scan_gap = scan_quiet ? 0 : pick_gap(30);
        end else begin
          scan_if.valid <= 1'b0;
        end
      end
      if (flags_stall > 0) begin
        flags_stall--;
        flags_if.ready <= 1'b0;
      end else begin
        flags_if.ready <= 1'b1;
        if ($urandom_range(0, 79) == 0) flags_quiet = !flags_quiet;
        flags_stall = flags_quiet ? 0 : pick_gap(25);
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsd_pkg::DEVICES; i++) begin
        on_q[i]  = '0;
        err_q[i] = '0;
      end
      chatter_ms = tsd_pkg::CHATTER_RESET;
      stuck_ms   = tsd_pkg::STUCK_RESET;
    end else begin
      if (cfg_we_i) begin
        case (tsd_pkg::tsd_reg_e'(cfg_idx_i))
          tsd_pkg::REG_CHATTER: chatter_ms = cfg_data_i[tsd_pkg::CHAT_W-1:0];
          tsd_pkg::REG_STUCK:   stuck_ms   = cfg_data_i[tsd_pkg::STUCK_W-1:0];
          default: ;
        endcase
      end
      if (scan_fire) begin
        expected_flags.push_back(apply_scan({scan_if.device_index, scan_if.switch_pattern,
                                             scan_if.time_ms}));
      end
      if (flags_fire) begin
        if (expected_flags.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want_flags = expected_flags.pop_front();
          if (flags_if.any_on !== want_flags.any_on)
            report_mismatch($sformatf("any_on got %b want %b",
                                      flags_if.any_on, want_flags.any_on));
          if (flags_if.on_mask !== want_flags.on_mask)
            report_mismatch($sformatf("on_mask got %h want %h",
                                      flags_if.on_mask, want_flags.on_mask));
          if (flags_if.error_mask !== want_flags.err_mask)
            report_mismatch($sformatf("error_mask got %h want %h",
                                      flags_if.error_mask, want_flags.err_mask));
        end
      end
    end
    scan_took <= rst_ni && scan_fire;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || scan_fire || flags_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[touch_switch_debounce_stuck_detect_unit] ERROR");
      $finish;
    end
  end

  initial begin
    scan_if.valid          = 1'b0;
    scan_if.device_index   = '0;
    scan_if.switch_pattern = '0;
    scan_if.time_ms        = '0;
    flags_if.ready         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // chatter window edges
    queue_scan(0, 16'hFFFF, 32'd100);
    queue_scan(0, 16'h0000, 32'd110);
    queue_scan(0, 16'h0000, 32'd120);
    queue_scan(0, 16'h0000, 32'd121);
    queue_scan(0, 16'hAAAA, 32'd0);
    // stuck limit edges, error held then cleared
    queue_scan(7, 16'h0001, 32'd1000);
    queue_scan(7, 16'h0001, 32'd11000);
    queue_scan(7, 16'h0001, 32'd11001);
    queue_scan(7, 16'h0001, 32'd11002);
    queue_scan(7, 16'h0000, 32'd0);
    queue_scan(7, 16'h0000, 32'd11003);
    queue_scan(7, 16'h0001, 32'd11004);
    // durations across the 32-bit wrap
    queue_scan(3, 16'h5555, 32'hFFFF_FFF0);
    queue_scan(3, 16'h0000, 32'h0000_0005);
    queue_scan(3, 16'h8001, 32'hFFFF_FFFF);
    queue_scan(3, 16'h8000, 32'h0000_0010);
    queue_scan(3, 16'h8000, 32'h0000_2711);
    queue_scan(3, 16'h0000, 32'h0000_2712);
    queue_scan(5, 16'hFFFF, 32'd0);
    queue_scan(5, 16'h1234, 32'd50);
    queue_scan(5, 16'h4321, 32'd60);
    queue_scan(5, 16'h0000, 32'd81);
    queue_scan(6, 16'hFFFF, 32'h8000_0000);
    queue_scan(6, 16'hFFFF, 32'h8000_2711);
    queue_random_scans(400, tsd_pkg::CHATTER_RESET, tsd_pkg::STUCK_RESET);
    wait_drained();

    apply_setting(0, 0);
    queue_random_scans(250, 0, 0);
    wait_drained();

    apply_setting(65535, 1000000);
    queue_random_scans(300, 65535, 1000000);
    wait_drained();

    apply_setting(3, 40);
    queue_random_scans(400, 3, 40);
    wait_drained();

    apply_setting(65535, 0);
    queue_random_scans(150, 65535, 0);
    wait_drained();

    apply_setting(0, 1000000);
    queue_random_scans(200, 0, 1000000);
    wait_drained();

    if (mismatches == 0) begin
      $display("[touch_switch_debounce_stuck_detect_unit] OK");
    end else begin
      $display("[touch_switch_debounce_stuck_detect_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ touch_switch_debounce_stuck_detect_unit.f @@
hdl/tsd_pkg.sv
hdl/tsd_in_if.sv
hdl/tsd_out_if.sv
hdl/tsd_cfg_regs.sv
hdl/tsd_switch_cell.sv
hdl/touch_switch_debounce_stuck_detect_unit.sv
hdl/tsd_checker.sv
sim/touch_switch_debounce_stuck_detect_unit_tb.sv
